>>> rtl/hpsm_pkg.sv
// Shared types, constants and tap-layout helpers for the Lt/Rt matrix
// with Hilbert phase shifter. No dependencies.
`default_nettype none

package hpsm_pkg;

  // Fixed-point constants used to build the coefficient table.
  localparam longint PI_Q28  = 64'sd843314857;
  localparam longint Q28_ONE = 64'sd1 << 28;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // input transfer, register the samples
    logic load;      // write histories, read delayed direct pair
    logic issue;     // one multiply-accumulate step
    logic finish;    // form and register Lt/Rt
    logic mode;      // phase shift on
  } hpsm_cmd_t;

  // First tap index with a nonzero coefficient (tap offset from center is odd).
  function automatic int first_tap(input int tap_count);
    int delay;
    delay = (tap_count - 1) / 2;
    return (delay % 2 == 1) ? 0 : 1;
  endfunction

  // Number of nonzero taps.
  function automatic int nz_count(input int tap_count);
    return (tap_count - first_tap(tap_count) + 1) / 2;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hpsm_if.sv
// Valid/ready channel interfaces for the sample input and the Lt/Rt output.
// No dependencies.
`default_nettype none

interface hpsm_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] direct_left;
  logic signed [SAMPLE_BITS-1:0] direct_right;
  logic signed [SAMPLE_BITS-1:0] surround_sum;

  modport source (output valid, output direct_left, output direct_right,
                  output surround_sum, input ready);
  modport sink   (input valid, input direct_left, input direct_right,
                  input surround_sum, output ready);
endinterface

interface hpsm_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] lt_sample;
  logic signed [SAMPLE_BITS-1:0] rt_sample;

  modport source (output valid, output lt_sample, output rt_sample, input ready);
  modport sink   (input valid, input lt_sample, input rt_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/hpsm_ctrl.sv
// Controller for the Lt/Rt matrix: sequences load, tap steps, pipeline
// drain and result hand-off. Holds the mode register. Uses hpsm_pkg.
`default_nettype none

module hpsm_ctrl #(
  parameter int TAP_COUNT = 127
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic              cfg_we,
  input  wire logic              cfg_data,
  output hpsm_pkg::hpsm_cmd_t    cmd
);
  import hpsm_pkg::*;

  localparam int NzCount = nz_count(TAP_COUNT);
  localparam int CntW    = $clog2(NzCount);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              mode_r, mode_nxt;
  logic              accept;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = cfg_we ? cfg_data : mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == ST_IDLE);
    accept        = in_valid && in_ready;
    cmd           = '0;
    cmd.mode      = mode_r;
    cmd.capture   = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = mode_r ? ST_LOAD : ST_FINISH;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (cnt_r == CntW'(NzCount - 1)) begin
          state_nxt = ST_DRAIN_A;
        end else begin
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      // These drain states wait while the last product passes through the product register into the accumulator.
      ST_DRAIN_A: state_nxt = ST_DRAIN_B;
      ST_DRAIN_B: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/hpsm_dpath.sv
// Datapath for the Lt/Rt matrix: surround history and direct delay memories,
// coefficient table, MAC pipeline, rounding and saturation. Uses hpsm_pkg.
`default_nettype none

module hpsm_dpath #(
  parameter int TAP_COUNT   = 127,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hpsm_pkg::hpsm_cmd_t           cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sum,
  output logic signed [SAMPLE_BITS-1:0]      out_lt,
  output logic signed [SAMPLE_BITS-1:0]      out_rt
);
  import hpsm_pkg::*;

  localparam int HistLen  = TAP_COUNT - 1;
  localparam int DelayLen = HistLen / 2;
  localparam int FirstTap = first_tap(TAP_COUNT);
  localparam int NzCount  = nz_count(TAP_COUNT);
  localparam int AddrW    = $clog2(TAP_COUNT);
  localparam int DAddrW   = $clog2(DelayLen);
  localparam int FillW    = $clog2(TAP_COUNT + 1);
  localparam int AgeW     = $clog2(TAP_COUNT + 3);
  localparam int ProdW    = SAMPLE_BITS + COEF_BITS;
  localparam int AccW     = ProdW + $clog2(NzCount);
  localparam int ShW      = AccW - COEF_BITS + 1;
  localparam int ExtW     = ShW + 1;
  localparam logic signed [ExtW-1:0] SatMax =
    ExtW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ExtW-1:0] SatMin = -SatMax - ExtW'(1);

  // Coefficient table, Hamming-windowed Hilbert taps built at elaboration.
  logic signed [COEF_BITS-1:0] coef_tab [TAP_COUNT];

  for (genvar gi = 0; gi < TAP_COUNT; gi++) begin : g_coef
    localparam longint N   = gi - DelayLen;
    localparam longint An  = (N < 0) ? -N : N;
    localparam longint J   = (2 * gi > HistLen) ? HistLen - gi : gi;
    localparam longint X   = (2 * PI_Q28 * J + HistLen / 2) / HistLen;
    localparam longint X2  = (X * X) >>> 28;
    // Taylor series of cos, each term truncated.
    localparam longint T1  = ((Q28_ONE * X2) >>> 28) / 2;
    localparam longint T2  = ((T1 * X2) >>> 28) / 12;
    localparam longint T3  = ((T2 * X2) >>> 28) / 30;
    localparam longint T4  = ((T3 * X2) >>> 28) / 56;
    localparam longint T5  = ((T4 * X2) >>> 28) / 90;
    localparam longint T6  = ((T5 * X2) >>> 28) / 132;
    localparam longint T7  = ((T6 * X2) >>> 28) / 182;
    localparam longint T8  = ((T7 * X2) >>> 28) / 240;
    localparam longint T9  = ((T8 * X2) >>> 28) / 306;
    localparam longint T10 = ((T9 * X2) >>> 28) / 380;
    localparam longint T11 = ((T10 * X2) >>> 28) / 462;
    localparam longint T12 = ((T11 * X2) >>> 28) / 552;
    localparam longint T13 = ((T12 * X2) >>> 28) / 650;
    localparam longint T14 = ((T13 * X2) >>> 28) / 756;
    localparam longint Cos = Q28_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7
                             + T8 - T9 + T10 - T11 + T12 - T13 + T14;
    localparam longint W100 = 54 * Q28_ONE - 46 * Cos;
    localparam longint Num  = 2 * W100 * (64'sd1 <<< (COEF_BITS - 1));
    localparam longint Den  = 100 * PI_Q28 * ((An == 0) ? 1 : An);
    localparam longint Mag  = (Num + Den / 2) / Den;
    localparam longint Coef = (An % 2 == 0) ? 0 : ((N < 0) ? -Mag : Mag);
    assign coef_tab[gi] = COEF_BITS'(Coef);
  end

  // Captured input samples.
  logic signed [SAMPLE_BITS-1:0] left_r, right_r, sum_r;

  // Surround history: circular buffer, newest sample written before the taps run.
  logic [SAMPLE_BITS-1:0]   hist_mem [TAP_COUNT];
  logic [AddrW-1:0]         head_r;
  logic [FillW-1:0]         fill_r;
  logic [AddrW-1:0]         rd_addr_r;
  logic [AgeW-1:0]          age_r;
  logic [AddrW-1:0]         rd_start;

  // Direct delay line: the slot at the head holds the oldest pair.
  logic [2*SAMPLE_BITS-1:0] dly_mem [DelayLen];
  logic [DAddrW-1:0]        dhead_r;
  logic [2*SAMPLE_BITS-1:0] dly_q_r;
  logic                     dly_ok_r;

  // MAC pipeline.
  logic                          s1_v_r, s2_v_r;
  logic [SAMPLE_BITS-1:0]        hist_q_r;
  logic signed [COEF_BITS-1:0]   coef_s1_r;
  logic                          age_ok_r;
  logic signed [SAMPLE_BITS-1:0] mac_samp;
  logic signed [ProdW-1:0]       prod_r;
  logic signed [AccW-1:0]        acc_r;

  // Result formation.
  logic signed [AccW-1:0]        acc_rnd;
  logic signed [ShW-1:0]         shifted;
  logic signed [SAMPLE_BITS-1:0] dl, dr;
  logic signed [ExtW-1:0]        a_l, a_r, b_ext, lt_ext, rt_ext;
  logic signed [SAMPLE_BITS-1:0] lt_sat, rt_sat;

  always_comb begin
    if (head_r >= AddrW'(FirstTap)) begin
      rd_start = head_r - AddrW'(FirstTap);
    end else begin
      rd_start = head_r + AddrW'(TAP_COUNT - FirstTap);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      left_r  <= in_left;
      right_r <= in_right;
      sum_r   <= in_sum;
    end
  end

  // Memories and their read registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hist_mem[head_r] <= sum_r;
      dly_q_r          <= dly_mem[dhead_r];
      dly_mem[dhead_r] <= {left_r, right_r};
      dly_ok_r         <= (fill_r >= FillW'(DelayLen));
      rd_addr_r        <= rd_start;
      age_r            <= AgeW'(FirstTap);
    end else if (cmd.issue) begin
      hist_q_r  <= hist_mem[rd_addr_r];
      coef_s1_r <= coef_tab[age_r[AddrW-1:0]];
      // Entries older than the number of samples written read as zero.
      age_ok_r  <= (age_r < AgeW'(fill_r));
      rd_addr_r <= (rd_addr_r < AddrW'(2)) ? rd_addr_r + AddrW'(TAP_COUNT - 2)
                                           : rd_addr_r - AddrW'(2);
      age_r     <= age_r + AgeW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      dhead_r <= '0;
      fill_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      if (cmd.load) begin
        head_r  <= (head_r == AddrW'(TAP_COUNT - 1)) ? '0 : head_r + AddrW'(1);
        dhead_r <= (dhead_r == DAddrW'(DelayLen - 1)) ? '0 : dhead_r + DAddrW'(1);
        if (fill_r != FillW'(TAP_COUNT)) begin
          fill_r <= fill_r + FillW'(1);
        end
      end
    end
  end

  assign mac_samp = age_ok_r ? signed'(hist_q_r) : '0;

  always_ff @(posedge clk) begin
    prod_r <= ProdW'(mac_samp) * ProdW'(coef_s1_r);
    if (cmd.load) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + {{(AccW - ProdW){prod_r[ProdW-1]}}, prod_r};
    end
  end

  // Round half up, then floor by the coefficient scale.
  assign acc_rnd = acc_r + (AccW'(1) <<< (COEF_BITS - 2));
  assign shifted = acc_rnd[AccW-1:COEF_BITS-1];

  assign dl = dly_ok_r ? signed'(dly_q_r[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
  assign dr = dly_ok_r ? signed'(dly_q_r[SAMPLE_BITS-1:0]) : '0;

  always_comb begin
    if (cmd.mode) begin
      a_l   = {{(ExtW - SAMPLE_BITS){dl[SAMPLE_BITS-1]}}, dl};
      a_r   = {{(ExtW - SAMPLE_BITS){dr[SAMPLE_BITS-1]}}, dr};
      b_ext = {shifted[ShW-1], shifted};
    end else begin
      a_l   = {{(ExtW - SAMPLE_BITS){left_r[SAMPLE_BITS-1]}}, left_r};
      a_r   = {{(ExtW - SAMPLE_BITS){right_r[SAMPLE_BITS-1]}}, right_r};
      b_ext = {{(ExtW - SAMPLE_BITS){sum_r[SAMPLE_BITS-1]}}, sum_r};
    end
    lt_ext = a_l - b_ext;
    rt_ext = a_r + b_ext;
    priority if (lt_ext > SatMax) begin
      lt_sat = SatMax[SAMPLE_BITS-1:0];
    end else if (lt_ext < SatMin) begin
      lt_sat = SatMin[SAMPLE_BITS-1:0];
    end else begin
      lt_sat = lt_ext[SAMPLE_BITS-1:0];
    end
    priority if (rt_ext > SatMax) begin
      rt_sat = SatMax[SAMPLE_BITS-1:0];
    end else if (rt_ext < SatMin) begin
      rt_sat = SatMin[SAMPLE_BITS-1:0];
    end else begin
      rt_sat = rt_ext[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_lt <= lt_sat;
      out_rt <= rt_sat;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hilbert_phase_shift_ltrt_matrix.sv
// Top level of the Lt/Rt matrix with Hilbert phase shifter on the surround path.
// Depends on hpsm_pkg, hpsm_if, hpsm_ctrl and hpsm_dpath.
//
// Each input transfer carries one weighted direct left, direct right and
// surround sum sample and yields one saturated Lt/Rt pair. With phase shift on,
// the surround sum runs through a Hamming-windowed Hilbert FIR and the direct
// paths are delayed by (TAP_COUNT-1)/2 samples; with it off the plain matrix
// is applied with no delay. One multiply-accumulate unit steps through the
// nonzero taps, one per cycle, reading the surround history memory. A new
// input transfer is taken only once the previous item is finished: with phase
// shift on after the load, tap steps, drain and finish, with it off after the
// finish alone. The result sits in an output register, so the next input
// can be taken while it waits. Histories start as zero after reset through a
// fill count, with no clearing pass. Write cfg_data while the block is idle.
`default_nettype none

module hilbert_phase_shift_ltrt_matrix #(
  parameter int TAP_COUNT   = 127,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hpsm_in_if.sink     in_ch,
  hpsm_out_if.source  out_ch,
  input  wire logic   cfg_we,
  input  wire logic   cfg_data
);
  import hpsm_pkg::*;

  hpsm_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;

  hpsm_ctrl #(
    .TAP_COUNT (TAP_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd)
  );

  hpsm_dpath #(
    .TAP_COUNT   (TAP_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_left  (in_ch.direct_left),
    .in_right (in_ch.direct_right),
    .in_sum   (in_ch.surround_sum),
    .out_lt   (out_ch.lt_sample),
    .out_rt   (out_ch.rt_sample)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
